@@ src/nearest_centroid_assign_unit_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef NEAREST_CENTROID_ASSIGN_UNIT_MACROS_SVH
`define NEAREST_CENTROID_ASSIGN_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NCA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/nca_pkg.sv @@
package nca_pkg;

   localparam int MAX_CLUSTERS = 16;
   localparam int MAX_DIMS     = 16;

   localparam int CLU_W   = 4;
   localparam int DIM_W   = 4;
   localparam int COORD_W = 16;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int DIST_W  = 36;
   localparam int CFG_W   = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   // Request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_POINT = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_CLUSTERS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_DIMS     = 2'd1;

   // Control handed from the sequencer to every cell
   typedef struct packed {
      logic                      load_en;
      logic [CLU_W-1:0]          load_cluster;
      logic [DIM_W-1:0]          load_dim;
      logic                      pt_en;
      logic [DIM_W-1:0]          pt_dim;
      logic signed [COORD_W-1:0] coord;
      logic                      sq_en;
      logic                      acc_en;
      logic                      acc_last;
      logic [CFG_W-1:0]          nclu;
   } cell_ctl_type;

   // Running minimum passed down the chain
   typedef struct packed {
      logic              valid;
      logic [CLU_W-1:0]  idx;
      logic [DIST_W-1:0] distance;
   } wave_type;

   // Zero acts as one, values above the maximum act as the maximum
   function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] maxv);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

@@ src/nca_ifs.sv @@
interface nca_req_if;
   logic                               valid;
   logic                               ready;
   logic                               req_type;
   logic [nca_pkg::CLU_W-1:0]          cluster_index;
   logic [nca_pkg::DIM_W-1:0]          dim_index;
   logic signed [nca_pkg::COORD_W-1:0] coord_value;

   modport source (output valid, req_type, cluster_index, dim_index, coord_value,
                   input ready);
   modport sink (input valid, req_type, cluster_index, dim_index, coord_value,
                 output ready);
endinterface

interface nca_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [nca_pkg::CLU_W-1:0]    best_cluster;
   logic [nca_pkg::DIST_W-1:0]   min_distance;

   modport source (output valid, best_cluster, min_distance, input ready);
   modport sink (input valid, best_cluster, min_distance, output ready);
endinterface

interface nca_csr_if;
   logic                              valid;
   logic                              ready;
   logic [nca_pkg::CSR_IDX_W-1:0]     index;
   logic [nca_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/nca_cell.sv @@
module nca_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [nca_pkg::CLU_W-1:0] cell_idx,
   input  nca_pkg::cell_ctl_type ctl,
   input  nca_pkg::wave_type     prev_wave,
   output nca_pkg::wave_type     next_wave
);
   import nca_pkg::*;

   logic [COORD_W-1:0] row_ff [MAX_DIMS];
   logic [COORD_W-1:0] diff_ff, diff_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [DIST_W-1:0]  acc_ff, acc_in;
   logic [DIST_W-1:0]  snap_ff, snap_in;
   wave_type           wave_ff, wave_in;

   logic signed [COORD_W:0] d;
   logic [DIST_W:0]         sum;
   logic [DIST_W-1:0]       sum_sat;
   logic                    take_own;

   // Centroid row of this cell; no reset, undefined until loaded
   always_ff @(posedge clock) begin
      if (ctl.load_en && ctl.load_cluster == cell_idx) begin
         row_ff[ctl.load_dim] <= ctl.coord;
      end
   end

   // Stage 1: absolute difference against the current coordinate
   always_comb begin
      d       = {ctl.coord[COORD_W-1], ctl.coord}
              - {row_ff[ctl.pt_dim][COORD_W-1], row_ff[ctl.pt_dim]};
      diff_in = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
   end

   // Stage 2: square
   assign sq_in = SQ_W'(diff_ff) * SQ_W'(diff_ff);

   // Stage 3: saturating accumulate, snapshot on the last coordinate
   always_comb begin
      sum     = {1'b0, acc_ff} + (DIST_W+1)'(sq_ff);
      sum_sat = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
      acc_in  = acc_ff;
      snap_in = snap_ff;
      if (ctl.acc_en) begin
         if (ctl.acc_last) begin
            snap_in = sum_sat;
            acc_in  = '0;
         end else begin
            acc_in = sum_sat;
         end
      end
   end

   // Minimum search: strict less-than keeps the lower index on ties
   always_comb begin
      take_own = (cell_idx == '0)
              || (({1'b0, cell_idx} < ctl.nclu) && (snap_ff < prev_wave.distance));
      wave_in       = prev_wave;
      if (take_own) begin
         wave_in.idx      = cell_idx;
         wave_in.distance = snap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pt_en) begin
         diff_ff <= diff_in;
      end
      if (ctl.sq_en) begin
         sq_ff <= sq_in;
      end
      snap_ff <= snap_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         wave_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         wave_ff <= wave_in;
      end
   end

   assign next_wave = wave_ff;

endmodule

@@ src/nearest_centroid_assign_unit.sv @@
// Nearest centroid assignment, one k-means assignment step in fixed point.
// req_bus: load requests (req_type 0) write one centroid coordinate at
//   cluster_index/dim_index; point requests (req_type 1) stream one signed
//   coordinate each, in dimension order.
// rsp_bus: one response per point, best_cluster and min_distance, carried
//   by the last active coordinate. Ties resolve to the lowest index.
// csr_bus: index 0 active_clusters, index 1 active_dims; always ready.
// Throughput: one coordinate per cycle within a point, set by the row of
//   16 cells that each square and accumulate against their own centroid.
// Path: after the last coordinate is accepted, its result passes the 3
//   arithmetic stages, a 16-cell minimum-search chain and the output
//   register. req_bus is held off until the response reaches the output
//   register.
// Stall: a finished response waits in the output register, and a second one
//   in a pending register; new coordinates are taken while only the output
//   register is full, and req_bus stays held off while the pending one waits.
// Reset: accumulators and coordinate counter clear, both registers return
//   to 16; centroid contents are undefined until loaded.
module nearest_centroid_assign_unit (
   input logic         clock,
   input logic         reset,
   nca_req_if.sink     req_bus,
   nca_rsp_if.source   rsp_bus,
   nca_csr_if.sink     csr_bus
);
   import nca_pkg::*;
   `include "nearest_centroid_assign_unit_macros.svh"

   logic [CFG_W-1:0] act_clu_ff, act_clu_in;
   logic [CFG_W-1:0] act_dims_ff, act_dims_in;
   logic [DIM_W-1:0] cnt_ff, cnt_in;
   logic             p1_valid_ff, p1_valid_in, p1_last_ff, p1_last_in;
   logic             p2_valid_ff, p2_valid_in, p2_last_ff, p2_last_in;
   logic             start_ff, start_in;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CLU_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [CLU_W-1:0] pend_idx_ff, pend_idx_in;
   logic [DIST_W-1:0] pend_dist_ff, pend_dist_in;

   logic             req_acc, pt_acc, load_acc, pt_last;
   logic [CFG_W-1:0] ndim, nclu;
   logic             out_free, rsp_from_wave, rsp_from_pend;
   cell_ctl_type     ctl;
   wave_type         wave [MAX_CLUSTERS+1];
   wave_type         wave_exit;

   // Configuration writes
   assign csr_bus.ready = 1'b1;
   always_comb begin
      act_clu_in  = act_clu_ff;
      act_dims_in = act_dims_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_ACTIVE_CLUSTERS: act_clu_in  = csr_bus.data;
            CSR_ACTIVE_DIMS:     act_dims_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   assign ndim = clamp_cfg(act_dims_ff, CFG_W'(MAX_DIMS));
   assign nclu = clamp_cfg(act_clu_ff, CFG_W'(MAX_CLUSTERS));

   // Request acceptance and coordinate counter
   assign req_bus.ready = !busy_ff;
   assign req_acc  = req_bus.valid && req_bus.ready;
   assign pt_acc   = req_acc && (req_bus.req_type == REQ_POINT);
   assign load_acc = req_acc && (req_bus.req_type == REQ_LOAD);
   assign pt_last  = (({1'b0, cnt_ff}) + CFG_W'(1)) >= ndim;

   always_comb begin
      cnt_in = cnt_ff;
      if (pt_acc) begin
         cnt_in = pt_last ? '0 : cnt_ff + DIM_W'(1);
      end
   end

   // Arithmetic stage tracking
   assign p1_valid_in = pt_acc;
   assign p1_last_in  = pt_acc && pt_last;
   assign p2_valid_in = p1_valid_ff;
   assign p2_last_in  = p1_last_ff;
   assign start_in    = p2_valid_ff && p2_last_ff;

   // Control to the cells
   always_comb begin
      ctl.load_en      = load_acc;
      ctl.load_cluster = req_bus.cluster_index;
      ctl.load_dim     = req_bus.dim_index;
      ctl.pt_en        = pt_acc;
      ctl.pt_dim       = cnt_ff;
      ctl.coord        = req_bus.coord_value;
      ctl.sq_en        = p1_valid_ff;
      ctl.acc_en       = p2_valid_ff;
      ctl.acc_last     = p2_last_ff;
      ctl.nclu         = nclu;
   end

   // Chain of cells, minimum search enters at cell 0
   assign wave[0].valid    = start_ff;
   assign wave[0].idx      = '0;
   assign wave[0].distance = '1;

   for (genvar j = 0; j < MAX_CLUSTERS; j++) begin : g_cell
      nca_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (CLU_W'(j)),
         .ctl       (ctl),
         .prev_wave (wave[j]),
         .next_wave (wave[j+1])
      );
   end

   assign wave_exit = wave[MAX_CLUSTERS];

   // Output register with one pending slot
   always_comb begin
      out_free      = !rsp_valid_ff || rsp_bus.ready;
      rsp_from_wave = wave_exit.valid && out_free;
      rsp_from_pend = pend_valid_ff && out_free;

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_dist_in  = rsp_dist_ff;
      if (rsp_from_wave) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = wave_exit.idx;
         rsp_dist_in  = wave_exit.distance;
      end else if (rsp_from_pend) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = pend_idx_ff;
         rsp_dist_in  = pend_dist_ff;
      end

      pend_valid_in = pend_valid_ff && !rsp_from_pend;
      pend_idx_in   = pend_idx_ff;
      pend_dist_in  = pend_dist_ff;
      if (wave_exit.valid && !out_free) begin
         pend_valid_in = 1'b1;
         pend_idx_in   = wave_exit.idx;
         pend_dist_in  = wave_exit.distance;
      end

      busy_in = busy_ff;
      if (pt_acc && pt_last) begin
         busy_in = 1'b1;
      end else if (rsp_from_wave || rsp_from_pend) begin
         busy_in = 1'b0;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.best_cluster = rsp_idx_ff;
   assign rsp_bus.min_distance = rsp_dist_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         act_clu_ff    <= CFG_W'(MAX_CLUSTERS);
         act_dims_ff   <= CFG_W'(MAX_DIMS);
         cnt_ff        <= '0;
         p1_valid_ff   <= 1'b0;
         p1_last_ff    <= 1'b0;
         p2_valid_ff   <= 1'b0;
         p2_last_ff    <= 1'b0;
         start_ff      <= 1'b0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         act_clu_ff    <= act_clu_in;
         act_dims_ff   <= act_dims_in;
         cnt_ff        <= cnt_in;
         p1_valid_ff   <= p1_valid_in;
         p1_last_ff    <= p1_last_in;
         p2_valid_ff   <= p2_valid_in;
         p2_last_ff    <= p2_last_in;
         start_ff      <= start_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_idx_ff   <= rsp_idx_in;
      rsp_dist_ff  <= rsp_dist_in;
      pend_idx_ff  <= pend_idx_in;
      pend_dist_ff <= pend_dist_in;
   end

   // A search leaving the chain always belongs to a point still in flight
   `NCA_ASSERT_NOW(a_exit_busy, clock, reset, wave_exit.valid, busy_ff && !pend_valid_ff,
                   "search result with no point in flight or slot already pending")
   // The pending slot fills only behind a stalled response
   `NCA_ASSERT_NOW(a_pend_behind_rsp, clock, reset, pend_valid_ff,
                   rsp_valid_ff && busy_ff, "pending response without a held output")
   // A search starts only after the last coordinate of an accepted point
   `NCA_ASSERT_NOW(a_start_busy, clock, reset, start_ff, busy_ff && cnt_ff == '0,
                   "search started outside a finished point")
   // Requests stay blocked for the whole search
   `NCA_ASSERT_NEXT(a_hold_off, clock, reset, start_ff, !req_bus.ready,
                    "request accepted during minimum search")

endmodule
